@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled during reset
`define CPOW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define CPOW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cpow_pkg.sv @@
// types and constants for the complex integer power unit
package cpow_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FINISH
  } cpow_state_t;

  // phases of one complex multiply on the shared multiplier
  typedef enum logic [2:0] {
    PH_MUL_RR,
    PH_MUL_II,
    PH_MUL_RI,
    PH_RND_RE,
    PH_ADD_IM,
    PH_RND_IM
  } cpow_phase_t;

  localparam int unsigned EXP_BITS = 8;

endpackage

@@ rtl/cpow_if.sv @@
// valid/ready channels for input samples and results

interface cpow_in_if #(
  parameter int W = 24
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] real_in;
  logic signed [W-1:0] imag_in;

  modport source (output valid, output real_in, output imag_in, input ready);
  modport sink   (input valid, input real_in, input imag_in, output ready);
endinterface

interface cpow_out_if #(
  parameter int W = 24
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] real_out;
  logic signed [W-1:0] imag_out;
  logic                overflow;

  modport source (output valid, output real_out, output imag_out, output overflow, input ready);
  modport sink   (input valid, input real_out, input imag_out, input overflow, output ready);
endinterface

@@ rtl/complex_integer_power_unit.sv @@
// Complex integer power unit: raises each complex sample to the configured
// exponent with one shared signed multiplier. Exponent 0 yields (1,0) and
// exponent 1 passes the sample through, both passing through ST_FINISH into
// the output register. For exponent e >= 2 the unit runs e-1 complex
// multiplies of the running value by the sample, each made of four products
// through the single multiplier and two round and saturate passes, before
// the result moves into the output register. A new sample is taken once the
// previous result has moved into the output register, so the unit takes no
// new sample while one is still in work; a result held by the receiver
// stalls the next load and with it the input. Exponents above MAX_EXPONENT
// act as MAX_EXPONENT; overflow reports any saturation along the way.
`include "assert_macros.svh"

module complex_integer_power_unit
  import cpow_pkg::*;
#(
  parameter int MAX_EXPONENT = 255,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  cpow_in_if.sink                sample,
  cpow_out_if.source             result,
  input  logic                   cfg_we,
  input  logic [EXP_BITS-1:0]    cfg_wdata
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FB    = SAMPLE_BITS - 8;
  localparam int PW    = 2 * SAMPLE_BITS;
  localparam int ACC_W = 2 * SAMPLE_BITS + 1;

  localparam int EXP_CAP = (MAX_EXPONENT < 255) ? MAX_EXPONENT : 255;
  localparam logic [EXP_BITS-1:0] EXP_CAP_W = EXP_BITS'(EXP_CAP);

  localparam logic signed [ACC_W-1:0] ONE_W = ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HI    = ONE_W <<< (SB - 1 + FB);
  localparam logic signed [ACC_W-1:0] HALF  = (ONE_W <<< FB) >>> 1;
  localparam logic signed [ACC_W-1:0] UPPER = HI - HALF;
  localparam logic signed [ACC_W-1:0] LOWER = -HI - HALF;

  localparam logic signed [SB-1:0] SMAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN  = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] UNITY = SB'(1) << FB;

  cpow_state_t state, state_next;
  cpow_phase_t ph;

  logic [EXP_BITS-1:0] exponent;
  logic [EXP_BITS-1:0] e_eff;
  logic [EXP_BITS-1:0] steps_left;

  logic signed [SB-1:0]    ra, ia, rt, it;
  logic signed [SB-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] t_sum;
  logic signed [ACC_W-1:0] rnd_shift;
  logic signed [SB-1:0]    rnd_val;
  logic                    rnd_sat;
  logic                    ovf;

  logic                    take;
  logic                    load_out;
  logic                    last_step;

  logic                    res_valid;
  logic signed [SB-1:0]    res_real;
  logic signed [SB-1:0]    res_imag;
  logic                    res_ovf;

  // exponent register
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXP_BITS'(1);
    end else if (cfg_we) begin
      exponent <= cfg_wdata;
    end
  end

  assign e_eff     = (exponent > EXP_CAP_W) ? EXP_CAP_W : exponent;
  assign take      = sample.valid && sample.ready;
  assign last_step = (steps_left == EXP_BITS'(1));

  // handshake and load controls
  always_comb begin
    sample.ready = (state == ST_IDLE);
    load_out     = (state == ST_FINISH) && (!res_valid || result.ready);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = (e_eff < EXP_BITS'(2)) ? ST_FINISH : ST_MUL;
        end
      end
      ST_MUL: begin
        if (ph == PH_RND_IM && last_step) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // multiplier operand select
  always_comb begin
    case (ph)
      PH_MUL_RR: begin mul_a = rt; mul_b = ra; end
      PH_MUL_II: begin mul_a = it; mul_b = ia; end
      PH_MUL_RI: begin mul_a = rt; mul_b = ia; end
      PH_RND_RE: begin mul_a = it; mul_b = ra; end
      default:   begin mul_a = rt; mul_b = ra; end
    endcase
  end

  assign prod_ext = {prod[PW-1], prod};

  // round half up, scale and saturate the accumulated sum
  always_comb begin
    t_sum     = acc + HALF;
    rnd_shift = t_sum >>> FB;
    if (acc >= UPPER) begin
      rnd_val = SMAX;
      rnd_sat = 1'b1;
    end else if (acc < LOWER) begin
      rnd_val = SMIN;
      rnd_sat = 1'b1;
    end else begin
      rnd_val = rnd_shift[SB-1:0];
      rnd_sat = 1'b0;
    end
  end

  // phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_MUL_RR;
    end else if (take) begin
      ph <= PH_MUL_RR;
    end else if (state == ST_MUL) begin
      ph <= (ph == PH_RND_IM) ? PH_MUL_RR : cpow_phase_t'(ph + 3'd1);
    end
  end

  // datapath: one product per cycle while in ST_MUL, accumulate, round
  always_ff @(posedge clk) begin
    if (take) begin
      ra         <= sample.real_in;
      ia         <= sample.imag_in;
      steps_left <= e_eff - EXP_BITS'(1);
      ovf        <= 1'b0;
      if (e_eff == '0) begin
        rt <= UNITY;
        it <= '0;
      end else begin
        rt <= sample.real_in;
        it <= sample.imag_in;
      end
    end else if (state == ST_MUL) begin
      prod <= mul_a * mul_b;
      case (ph)
        PH_MUL_II: acc <= prod_ext;
        PH_MUL_RI: acc <= acc - prod_ext;
        PH_RND_RE: begin
          rt  <= rnd_val;
          ovf <= ovf | rnd_sat;
          acc <= prod_ext;
        end
        PH_ADD_IM: acc <= acc + prod_ext;
        PH_RND_IM: begin
          it         <= rnd_val;
          ovf        <= ovf | rnd_sat;
          steps_left <= steps_left - EXP_BITS'(1);
        end
        default: acc <= acc;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_real <= rt;
      res_imag <= it;
      res_ovf  <= ovf;
    end
  end

  assign result.valid    = res_valid;
  assign result.real_out = res_real;
  assign result.imag_out = res_imag;
  assign result.overflow = res_ovf;

  // checks
  `CPOW_ASSERT(a_busy_after_take, clk, rst, take |=> !sample.ready, "sample taken while busy")
  `CPOW_ASSERT(a_trivial_finish, clk, rst, (take && (e_eff < EXP_BITS'(2))) |=> (state == ST_FINISH), "trivial exponent did not finish")
  `CPOW_ASSERT(a_hold_finish, clk, rst, (state == ST_FINISH && res_valid && !result.ready) |=> (state == ST_FINISH), "result overwritten before taken")
  `CPOW_ASSERT(a_steps_nonzero, clk, rst, (state == ST_MUL) |-> (steps_left != '0), "step count ran out while multiplying")

endmodule
